// ===== design/stfs_pkg.sv =====
// ----------------------------------------------------------------------------
// stfs_pkg: shared types and constants of the sorted table floor search
// Beat formats, configuration register indexes, command codes, controller
// states and the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package stfs_pkg;

	localparam int SLOT_W      = 10;
	localparam int OFFSET_W    = 32;
	localparam int ADDR_W      = 64;
	localparam int COUNT_W     = 11;
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 64;

	localparam logic [CFG_INDEX_W-1:0] CFG_TABLE_BASE  = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] CFG_ENTRY_COUNT = 1'b1;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef struct packed {
		logic                       cmd;
		logic [SLOT_W-1:0]          slot;
		logic signed [OFFSET_W-1:0] offset;
		logic [ADDR_W-1:0]          key;
	} in_item_t;

	typedef struct packed {
		logic [SLOT_W-1:0] found_index;
		logic              found;
	} out_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_COMPARE
	} ctl_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;    // write one entry of the offset store
		logic init;    // open a search over the whole table
		logic issue;   // read the probe entry and form its base part
		logic update;  // compare the probe against the key, narrow the range
		logic finish;  // present the result beat
	} ctl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic more;    // the search range is not yet empty
	} ctl_sts_t;

endpackage

`default_nettype wire

// ===== design/sorted_table_floor_search.sv =====
// ----------------------------------------------------------------------------
// sorted_table_floor_search: floor search in a table of self-relative offsets
// Holds signed 32-bit offsets; entry i decodes to table_base + 4*i + offset.
// A load beat writes one entry, a query beat binary-searches the table for
// the rightmost entry whose decoded address is at or below the key.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake                    Payload                Direction
//   -------   --------------------------   --------------------   ---------
//   input     start, taken when !busy      item  (in_item_t)      in
//   result    done, one cycle, no stall    result (out_item_t)    out
//   config    cfg_we, written every edge   cfg_index, cfg_wdata   in
//
// A load beat leaves the block ready for the next beat. A query beat
// holds busy high until its search is through, so no beat is taken in
// between. It makes k probes, at most floor(log2(n)) + 1 for n entries;
// each probe is one read of the offset store and one 64-bit add and
// compare. The result beat is shown on done in the cycle in which busy
// falls again.
// Reset clears the configuration and the controller; the offset store has no
// reset and must be written before it is searched. The receiver cannot stall
// results, so none is ever held back.
//
`default_nettype none

module sorted_table_floor_search
	import stfs_pkg::*;
#(
	parameter int MAX_ENTRIES = 1024
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	output logic                        busy,
	input  wire in_item_t               item,
	output logic                        done,
	output out_item_t                   result,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

	ctl_cmd_t ctl_cmd;
	ctl_sts_t ctl_sts;

	// The controller sequences each query: an issue state starts a store
	// read at the probe point, a compare state narrows the range, and an
	// issue state that finds the range empty releases the result.
	stfs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.item_cmd (item.cmd),
		.sts      (ctl_sts),
		.busy     (busy),
		.cmd      (ctl_cmd)
	);

	// The datapath holds the registers, the offset store and the search range.
	stfs_dp #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.item      (item),
		.cmd       (ctl_cmd),
		.sts       (ctl_sts),
		.done      (done),
		.result    (result)
	);

endmodule

`default_nettype wire

// ===== design/stfs_ram.sv =====
// ----------------------------------------------------------------------------
// stfs_ram: generic single-port-write, single-port-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module stfs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== design/stfs_dp.sv =====
// ----------------------------------------------------------------------------
// stfs_dp: datapath of the sorted table floor search
// Configuration registers, offset store, search range registers and the
// address decode and compare against the key.
// ----------------------------------------------------------------------------
`default_nettype none

module stfs_dp
	import stfs_pkg::*;
#(
	parameter int MAX_ENTRIES = 1024
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
	input  wire in_item_t               item,
	input  wire ctl_cmd_t               cmd,
	output ctl_sts_t                    sts,
	output logic                        done,
	output out_item_t                   result
);

	localparam int IW = $clog2(MAX_ENTRIES);
	localparam int NW = $clog2(MAX_ENTRIES + 1);
	localparam int EW = (NW > COUNT_W) ? NW : COUNT_W;

	logic [ADDR_W-1:0]   base_q;
	logic [COUNT_W-1:0]  count_q;
	logic [ADDR_W-1:0]   key_q;
	logic [NW-1:0]       lo_q;
	logic [NW-1:0]       hi_q;      // exclusive upper bound
	logic [IW-1:0]       best_q;
	logic [IW-1:0]       mid_q;
	logic [ADDR_W-1:0]   part_q;
	logic                found_q;
	logic                done_q;
	out_item_t           result_q;

	logic [EW-1:0]       cnt_ext;
	logic [NW-1:0]       n_sat;
	logic [NW-1:0]       span;
	logic [NW-1:0]       mid;
	logic                slot_ok;
	logic [OFFSET_W-1:0] rdata;
	logic [ADDR_W-1:0]   addr;
	logic                at_or_below;

	// Entry count saturates at the depth of the store.
	assign cnt_ext = EW'(count_q);
	assign n_sat   = (cnt_ext > EW'(MAX_ENTRIES)) ? NW'(MAX_ENTRIES) : NW'(cnt_ext);

	// Probe point of the current range; only meaningful while it is not empty.
	assign span = hi_q - lo_q - NW'(1);
	assign mid  = lo_q + (span >> 1);

	assign slot_ok = ({22'd0, item.slot} < 32'(MAX_ENTRIES));

	stfs_ram #(
		.WIDTH(OFFSET_W),
		.DEPTH(MAX_ENTRIES)
	) u_store (
		.clk   (clk),
		.we    (cmd.load && slot_ok),
		.waddr (IW'(item.slot)),
		.wdata (item.offset),
		.re    (cmd.issue),
		.raddr (IW'(mid)),
		.rdata (rdata)
	);

	// The base part of the address is formed while the store is read, so the
	// compare cycle holds a single wide add and compare.
	assign addr        = part_q + {{(ADDR_W - OFFSET_W){rdata[OFFSET_W-1]}}, rdata};
	assign at_or_below = (addr <= key_q);

	assign sts.more = (lo_q < hi_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= '0;
			count_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_TABLE_BASE:  base_q  <= cfg_wdata;
				CFG_ENTRY_COUNT: count_q <= cfg_wdata[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.finish;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.init) begin
			key_q   <= item.key;
			lo_q    <= '0;
			hi_q    <= n_sat;
			best_q  <= '0;
			found_q <= (n_sat != '0);
		end
		if (cmd.issue) begin
			mid_q  <= IW'(mid);
			part_q <= base_q + (ADDR_W'(mid) << 2);
		end
		if (cmd.update) begin
			if (at_or_below) begin
				best_q <= mid_q;
				lo_q   <= NW'(mid_q) + NW'(1);
			end else begin
				hi_q <= NW'(mid_q);
			end
		end
		if (cmd.finish) begin
			result_q.found_index <= SLOT_W'(best_q);
			result_q.found       <= found_q;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

`default_nettype wire

// ===== design/stfs_ctrl.sv =====
// ----------------------------------------------------------------------------
// stfs_ctrl: controller of the sorted table floor search
// Accepts beats; for a query beat it steps the datapath through read and
// compare cycles until the search range is empty.
// ----------------------------------------------------------------------------
`default_nettype none

module stfs_ctrl
	import stfs_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	input  wire logic     item_cmd,
	input  wire ctl_sts_t sts,
	output logic          busy,
	output ctl_cmd_t      cmd
);

	ctl_state_t state_q;
	ctl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start && item_cmd == CMD_QUERY) begin
					state_d = ST_ISSUE;
				end
			end
			ST_ISSUE: begin
				state_d = sts.more ? ST_COMPARE : ST_IDLE;
			end
			ST_COMPARE: begin
				state_d = ST_ISSUE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		case (state_q)
			ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = start && item_cmd == CMD_LOAD;
				cmd.init = start && item_cmd == CMD_QUERY;
			end
			ST_ISSUE: begin
				cmd.issue  = sts.more;
				cmd.finish = !sts.more;
			end
			ST_COMPARE: begin
				cmd.update = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== tb/tb_sorted_table_floor_search.sv =====
// ----------------------------------------------------------------------------
// tb_sorted_table_floor_search: self-checking bench for the floor search block
// Loads tables of self-relative offsets, mostly sorted by decoded address,
// and fires queries with keys placed on, just below and just above the
// entries. A scoreboard repeats the binary search on its own copy of the
// table and registers and compares every result beat field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_sorted_table_floor_search;
	import stfs_pkg::*;

	localparam int DEPTH       = 1024;
	localparam int ITEMS       = 1600;
	localparam int STALL_LIMIT = 2000;
	localparam int SETTLE      = 4;
	localparam longint OFF_MIN = -(64'sd1 <<< 31);
	localparam longint OFF_MAX = (64'sd1 <<< 31) - 1;

	// The scoreboard keeps its own image of the offset store and of both
	// registers, and predicts the floor index for every query beat.
	class floor_search_board;
		logic [OFFSET_W-1:0] offsets [DEPTH];
		logic [ADDR_W-1:0]   base;
		logic [COUNT_W-1:0]  count;
		out_item_t           expected_floors [$];
		int unsigned         fails;

		function new();
			foreach (offsets[i])
				offsets[i] = '0;
			base = '0;
			count = '0;
			fails = 0;
		endfunction

		function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_TABLE_BASE: begin
					base = data;
				end
				CFG_ENTRY_COUNT: begin
					count = data[COUNT_W-1:0];
				end
				default: begin
				end
			endcase
		endfunction

		// Entry i sits at base + 4*i + offset, with the offset sign-extended
		// and the sum wrapping at 64 bits.
		function logic [ADDR_W-1:0] entry_addr(int idx);
			return base + (64'(idx) << 2) + {{32{offsets[idx][OFFSET_W-1]}}, offsets[idx]};
		endfunction

		function out_item_t predict_floor(logic [ADDR_W-1:0] key);
			out_item_t res;
			int n, lo, hi, mid, best;
			res = '0;
			// Counts above the table depth saturate at the depth.
			n = (int'(count) > DEPTH) ? DEPTH : int'(count);
			if (n == 0)
				return res;
			lo = 0;
			hi = n - 1;
			best = 0;
			while (lo <= hi) begin
				mid = lo + (hi - lo) / 2;
				if (entry_addr(mid) <= key) begin
					best = mid;
					lo = mid + 1;
				end else begin
					hi = mid - 1;
				end
			end
			res.found_index = SLOT_W'(best);
			res.found = 1'b1;
			return res;
		endfunction

		function void note_beat(in_item_t beat);
			if (beat.cmd == CMD_QUERY)
				expected_floors.push_back(predict_floor(beat.key));
			else if (int'(beat.slot) < DEPTH)
				offsets[beat.slot] = beat.offset;
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			if (expected_floors.size() == 0) begin
				$error("result: beat with nothing expected, found_index %0d found %0d",
					got.found_index, got.found);
				fails++;
				return;
			end
			want = expected_floors.pop_front();
			if (got.found !== want.found) begin
				$error("found: expected %0d, got %0d", want.found, got.found);
				fails++;
			end
			if (got.found_index !== want.found_index) begin
				$error("found_index: expected %0d, got %0d", want.found_index, got.found_index);
				fails++;
			end
		endfunction

		function int pending();
			return expected_floors.size();
		endfunction
	endclass

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   start     = 1'b0;
	logic                   busy;
	in_item_t               beat_in   = '0;
	logic                   done;
	out_item_t              result;
	logic                   cfg_we    = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = CFG_TABLE_BASE;
	logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

	floor_search_board board = new();

	// Stimulus-side image of the table, used only to aim keys at entries.
	logic [OFFSET_W-1:0] table_img [DEPTH];
	logic [ADDR_W-1:0]   cur_base  = '0;
	int                  cur_count = 0;
	int unsigned         beats_sent = 0;
	bit                  no_idle = 1'b0;
	int unsigned         stall_cycles = 0;

	always #2 clk = ~clk;

	sorted_table_floor_search #(
		.MAX_ENTRIES(DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(beat_in),
		.done(done),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	// Everything is sampled on the rising edge, before this edge's updates
	// land, so the monitor sees exactly what the block sees. The result is
	// checked before a beat taken at the same edge is noted.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				board.check_result(result);
			if (start && !busy)
				board.note_beat(beat_in);
			if (cfg_we)
				board.write_reg(cfg_index, cfg_wdata);
		end
	end

	// A run that stops moving for too long is a failure.
	initial begin : watchdog
		while (stall_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((start && !busy) || done || cfg_we)
				stall_cycles = 0;
			else
				stall_cycles++;
		end
		$display("sorted_table_floor_search: mismatch");
		$finish;
	end

	function automatic logic [ADDR_W-1:0] addr_of(int idx);
		return cur_base + (64'(idx) << 2) + {{32{table_img[idx][OFFSET_W-1]}}, table_img[idx]};
	endfunction

	// Mostly no gap, often a short one, now and then a long one.
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [CFG_DATA_W-1:0] count_word(int n);
		logic [CFG_DATA_W-1:0] w;
		// The bits above the count field are don't-care; half the time they
		// carry noise.
		w = ($urandom_range(0, 1) != 0) ? {$urandom, $urandom} : '0;
		w[COUNT_W-1:0] = COUNT_W'(n);
		return w;
	endfunction

	// Keys land on an entry, one either side of it, a little above it, below
	// the first entry, at either end of the address space, or anywhere at all.
	function automatic logic [ADDR_W-1:0] pick_key(int n);
		int unsigned r;
		int          j;
		r = $urandom_range(0, 99);
		if (n == 0 || r >= 92)
			return {$urandom, $urandom};
		j = $urandom_range(0, n - 1);
		if (r < 30)
			return addr_of(j);
		if (r < 50)
			return addr_of(j) - 1;
		if (r < 70)
			return addr_of(j) + 1;
		if (r < 78)
			return addr_of(j) + $urandom_range(2, 7);
		if (r < 84)
			return addr_of(0) - 1;
		if (r < 88)
			return '0;
		return '1;
	endfunction

	task automatic cfg_write(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_index <= idx;
		cfg_wdata <= data;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_table(logic [ADDR_W-1:0] base, logic [CFG_DATA_W-1:0] cw);
		cfg_write(CFG_TABLE_BASE, base);
		cfg_write(CFG_ENTRY_COUNT, cw);
		cur_base = base;
		cur_count = (int'(cw[COUNT_W-1:0]) > DEPTH) ? DEPTH : int'(cw[COUNT_W-1:0]);
	endtask

	// Offers one beat and holds it until the block takes it, then idles for
	// a random gap. With no gap, start simply stays high for the next beat.
	task automatic issue_beat(in_item_t beat);
		int unsigned gap;
		beat_in <= beat;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		beats_sent++;
		gap = pick_gap();
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Drops start, waits for every expected result and for busy to fall, then
	// lets the clock run on so that a trailing load beat has surely been written.
	task automatic settle();
		start <= 1'b0;
		do @(posedge clk); while (board.pending() != 0 || busy);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic load_entry(int slot, logic [OFFSET_W-1:0] off);
		in_item_t beat;
		beat.cmd = CMD_LOAD;
		beat.slot = SLOT_W'(slot);
		beat.offset = off;
		beat.key = {$urandom, $urandom};
		table_img[slot] = off;
		issue_beat(beat);
	endtask

	task automatic query(logic [ADDR_W-1:0] key);
		in_item_t beat;
		beat.cmd = CMD_QUERY;
		beat.slot = SLOT_W'($urandom);
		beat.offset = $urandom;
		beat.key = key;
		issue_beat(beat);
	endtask

	// Fills slots 0 to n-1 so that decoded addresses never fall: an offset
	// may drop by at most four from one slot to the next. Equal addresses
	// and the odd big jump are included; wrapping of the decoded address at
	// 64 bits may break the order, which the search must cope with just the same.
	task automatic load_sorted(int n);
		longint off;
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r == 0)
			off = OFF_MIN;
		else
			off = longint'(int'($urandom)) / 2;
		for (int i = 0; i < n; i++) begin
			load_entry(i, OFFSET_W'(off));
			if ($urandom_range(0, 15) == 0)
				off += $urandom_range(0, 1 << 20);
			else
				off += longint'($urandom_range(0, 12)) - 4;
			if (off > OFF_MAX)
				off = OFF_MAX;
			if (off < OFF_MIN)
				off = OFF_MIN;
		end
	endtask

	// Queries with an occasional load to any slot mixed in as noise. Only
	// called once every slot has been written.
	task automatic run_queries(int q);
		repeat (q) begin
			if ($urandom_range(0, 9) == 0)
				load_entry($urandom_range(0, DEPTH - 1), $urandom);
			else
				query(pick_key(cur_count));
		end
	endtask

	initial begin : stimulus
		int unsigned r;
		int          n;
		logic [ADDR_W-1:0]     base;
		logic [CFG_DATA_W-1:0] cw;

		foreach (table_img[i])
			table_img[i] = '0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. After reset the table is empty: not found.
		query('0);
		query('1);

		// A base near the top of the address space, so that decoding wraps,
		// and offsets at both extremes.
		settle();
		set_table(64'hFFFF_FFFF_FFFF_FFF0, '0);
		load_entry(0, 32'h8000_0000);
		load_entry(1, 32'h0000_0000);
		load_entry(2, 32'h7FFF_FFFF);
		load_entry(3, 32'hFFFF_FFFF);
		load_entry(DEPTH - 1, 32'h7FFF_FFFF);
		settle();
		set_table(64'hFFFF_FFFF_FFFF_FFF0, 64'd4);
		query('0);
		query('1);
		query(addr_of(0));
		query(addr_of(0) - 1);
		query(addr_of(1));
		query(addr_of(2));

		// One entry only, with keys at both ends: index 0 with found set either way.
		settle();
		set_table(64'hFFFF_FFFF_FFFF_FFF0, 64'd1);
		query('0);
		query('1);

		// A zero base with a sorted tail entry.
		settle();
		set_table('0, 64'd4);
		load_entry(3, 32'd100);
		query('0);
		query(addr_of(3));
		query(addr_of(3) - 1);

		// Full table, then counts beyond the depth, which saturate.
		settle();
		set_table({$urandom, $urandom}, 64'd1024);
		load_sorted(DEPTH);
		run_queries(40);
		settle();
		cw = count_word(2047);
		set_table(cur_base, cw);
		run_queries(20);
		settle();
		set_table({$urandom, $urandom}, count_word(DEPTH + $urandom_range(1, DEPTH - 1)));
		run_queries(15);

		// Random phases, mostly small sorted tables with keys aimed at them.
		while (beats_sent < ITEMS) begin
			settle();
			no_idle = ($urandom_range(0, 3) == 0);
			r = $urandom_range(0, 99);
			if (r < 10)
				base = '0;
			else if (r < 20)
				base = '1;
			else if (r < 35)
				base = {32'hFFFF_FFFF, $urandom};
			else
				base = {$urandom, $urandom};
			r = $urandom_range(0, 99);
			if (r < 8)
				n = 0;
			else if (r < 75)
				n = $urandom_range(1, 16);
			else if (r < 95)
				n = $urandom_range(17, 128);
			else
				n = $urandom_range(129, DEPTH);
			set_table(base, count_word(n));
			// Large tables keep their old contents; small ones are usually
			// rebuilt sorted against the new base.
			if (n > 0 && n <= 128 && $urandom_range(0, 4) != 0)
				load_sorted(n);
			run_queries($urandom_range(10, 30));
		end

		settle();
		repeat (30) @(posedge clk);
		@(negedge clk);
		if (board.fails == 0 && board.pending() == 0)
			$display("sorted_table_floor_search: match");
		else
			$display("sorted_table_floor_search: mismatch");
		$finish;
	end

endmodule

`default_nettype wire

// ===== sorted_table_floor_search.f =====
design/stfs_pkg.sv
design/stfs_ram.sv
design/stfs_dp.sv
design/stfs_ctrl.sv
design/sorted_table_floor_search.sv
tb/tb_sorted_table_floor_search.sv
